// ===== src/rgb_to_256_colour_index_unit_defines.svh =====
// assertion macros for the rgb to 256 colour index unit
`ifndef RGB_TO_256_COLOUR_INDEX_UNIT_DEFINES_SVH
`define RGB_TO_256_COLOUR_INDEX_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RGBI_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rgbi assertion failed");

// next-cycle implication
`define RGBI_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rgbi assertion failed");

`else

`define RGBI_ASSERT_NOW(label, ck, rs, ante, cons)
`define RGBI_ASSERT_NEXT(label, ck, rs, ante, cons)

`endif

`endif

// ===== src/rgbi_pkg.sv =====
// shared types, constants and arithmetic helpers for the colour index unit
`default_nettype none

package rgbi_pkg;

  // register map (word index)
  localparam logic REG_GRAY_WINDOW = 1'b0;

  localparam logic [7:0] GRAY_WINDOW_RESET = 8'd22;
  localparam logic [7:0] CUBE_BASE         = 8'd16;
  localparam logic [7:0] GRAY_BASE         = 8'd232;
  localparam logic [7:0] CUBE_RED_STEP     = 8'd36;
  localparam logic [7:0] CUBE_GREEN_STEP   = 8'd6;
  localparam logic [7:0] GRAY_STEPS        = 8'd24;
  localparam logic [10:0] CUBE_LEVELS      = 11'd6;

  // reciprocal of 3 in 11 fractional bits, exact for sums up to 765
  localparam logic [18:0] RECIP3 = 19'd683;

  // per-stage load enables of a colour lane
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  // x / 255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] s;
    s = x + {8'd0, x[15:8]} + 16'd1;
    return s[15:8];
  endfunction

  // channel sum / 3
  function automatic logic [7:0] div3(input logic [9:0] sum);
    logic [18:0] prod;
    prod = {9'd0, sum} * RECIP3;
    return prod[18:11];
  endfunction

  // cube level 0..5 of a channel
  function automatic logic [2:0] quant6(input logic [7:0] p);
    logic [10:0] prod;
    prod = {3'd0, p} * CUBE_LEVELS;
    return prod[10:8];
  endfunction

  // gray ramp index 232..255
  function automatic logic [7:0] gray_index(input logic [7:0] lum);
    logic [12:0] prod;
    prod = {5'd0, lum} * {5'd0, GRAY_STEPS};
    return GRAY_BASE + {3'd0, prod[12:8]};
  endfunction

  // cube index 16..231
  function automatic logic [7:0] cube_index(input logic [2:0] qr, input logic [2:0] qg,
                                            input logic [2:0] qb);
    return CUBE_BASE + {5'd0, qr} * CUBE_RED_STEP + {5'd0, qg} * CUBE_GREEN_STEP
           + {5'd0, qb};
  endfunction

endpackage

`default_nettype wire

// ===== src/rgbi_lane.sv =====
// one colour lane: premultiply, luminance, gray test and palette index
`default_nettype none

module rgbi_lane
  import rgbi_pkg::*;
(
  input  wire logic       clk,
  input  wire pipe_en_t   en,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic [7:0] alpha,
  input  wire logic [7:0] gray_window,
  output logic      [7:0] index
);

  logic [15:0] prod [3];
  logic [7:0]  pm   [3];
  logic [7:0]  pm3  [3];
  logic [2:0]  q    [3];
  logic [7:0]  lum;
  logic [9:0]  sum;
  logic [9:0]  lo_test;
  logic [9:0]  hi_bound;
  logic        off_gray;

  // stage 1: channel times alpha
  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod[0] <= red * alpha;
      prod[1] <= green * alpha;
      prod[2] <= blue * alpha;
    end
  end

  // stage 2: divide by 255
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int k = 0; k < 3; k++) begin
        pm[k] <= div255(prod[k]);
      end
    end
  end

  // stage 3: luminance and cube levels
  assign sum = {2'd0, pm[0]} + {2'd0, pm[1]} + {2'd0, pm[2]};

  always_ff @(posedge clk) begin
    if (en.s3) begin
      lum <= div3(sum);
      for (int k = 0; k < 3; k++) begin
        pm3[k] <= pm[k];
        q[k]   <= quant6(pm[k]);
      end
    end
  end

  // window test and index select
  assign hi_bound = {2'd0, lum} + {2'd0, gray_window};

  always_comb begin
    off_gray = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo_test = {2'd0, pm3[k]} + {2'd0, gray_window};
      if (lo_test < {2'd0, lum} || {2'd0, pm3[k]} > hi_bound) begin
        off_gray = 1'b1;
      end
    end
    index = off_gray ? cube_index(q[0], q[1], q[2]) : gray_index(lum);
  end

endmodule

`default_nettype wire

// ===== src/rgbi_merge.sv =====
// output register that joins the two lane results into one transaction
`default_nettype none

module rgbi_merge
  import rgbi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       lane_valid,
  input  wire logic [7:0] lane_back,
  input  wire logic [7:0] lane_fore,
  output logic            ready,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] back_index,
  output logic      [7:0] fore_index
);

  // takes a new result when empty or when the held one leaves
  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && lane_valid) begin
      back_index <= lane_back;
      fore_index <= lane_fore;
    end
  end

endmodule

`default_nettype wire

// ===== src/rgb_to_256_colour_index_unit.sv =====
// top level: register port, lane pipeline control and output stage
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  input   | in        | in_valid / in_stall   | back_* and fore_* rgba bytes
//  output  | out       | out_valid / out_stall | back_index, fore_index
//  config  | in        | apb psel / penable    | gray_window at byte address 0
//
//  one transaction per cycle sustained while out_stall is low; after the input accept a
//  transaction passes product (loaded at the accept edge), divide by 255, luminance, output register
//  each pipeline stage loads when it is empty or its successor loads, so bubbles close up
//  a stall on the output backs up through the stages to in_stall
//  reset clears all valid bits and sets gray_window to 22
`default_nettype none
`include "rgb_to_256_colour_index_unit_defines.svh"

module rgb_to_256_colour_index_unit
  import rgbi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  back_red,
  input  wire logic [7:0]  back_green,
  input  wire logic [7:0]  back_blue,
  input  wire logic [7:0]  back_alpha,
  input  wire logic [7:0]  fore_red,
  input  wire logic [7:0]  fore_green,
  input  wire logic [7:0]  fore_blue,
  input  wire logic [7:0]  fore_alpha,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  back_index,
  output logic      [7:0]  fore_index,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic       [7:0] gray_window;
  logic             v1;
  logic             v2;
  logic             v3;
  logic             merge_ready;
  pipe_en_t         en;
  logic             cfg_write;
  logic       [7:0] back_lane;
  logic       [7:0] fore_lane;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_window <= GRAY_WINDOW_RESET;
    end else if (cfg_write && paddr[2] == REG_GRAY_WINDOW) begin
      gray_window <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_GRAY_WINDOW) begin
      prdata = {24'd0, gray_window};
    end
  end

  // stage enables, bubble collapsing
  always_comb begin
    en.s3 = !v3 || merge_ready;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign in_stall = !en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en.s1) v1 <= in_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
    end
  end

  // colour lanes
  rgbi_lane u_back_lane (
    .clk        (clk),
    .en         (en),
    .red        (back_red),
    .green      (back_green),
    .blue       (back_blue),
    .alpha      (back_alpha),
    .gray_window(gray_window),
    .index      (back_lane)
  );

  rgbi_lane u_fore_lane (
    .clk        (clk),
    .en         (en),
    .red        (fore_red),
    .green      (fore_green),
    .blue       (fore_blue),
    .alpha      (fore_alpha),
    .gray_window(gray_window),
    .index      (fore_lane)
  );

  // output stage
  rgbi_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lane_valid(v3),
    .lane_back (back_lane),
    .lane_fore (fore_lane),
    .ready     (merge_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .back_index(back_index),
    .fore_index(fore_index)
  );

  // checks
  `RGBI_ASSERT_NOW(a_empty_front_accepts, clk, rst, !v1, !in_stall)
  `RGBI_ASSERT_NEXT(a_last_stage_moves_out, clk, rst, v3 && merge_ready, out_valid)
  `RGBI_ASSERT_NEXT(a_stall_holds_last_stage, clk, rst, out_valid && out_stall && v3, v3)
  `RGBI_ASSERT_NEXT(a_window_write, clk, rst, cfg_write && paddr[2] == REG_GRAY_WINDOW,
                    gray_window == $past(pwdata[7:0]))

endmodule

`default_nettype wire

// ===== verif/rgb_to_256_colour_index_unit_test.sv =====
// testbench for the rgb to 256 colour index unit: random and directed pixels, scoreboard check
`timescale 1ns / 1ps

module rgb_to_256_colour_index_unit_test;
  import rgbi_pkg::*;

  // register map and timing
  localparam logic [2:0] GRAY_WINDOW_ADDR = 3'(REG_GRAY_WINDOW) << 2;
  localparam logic [2:0] UNMAPPED_ADDR    = 3'd4;
  localparam int         PIPE_LATENCY     = 4;
  localparam int         MAX_IDLE         = 17;

  // palette layout
  localparam int CUBE_START = 16;
  localparam int GRAY_START = 232;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    rgba_t back;
    rgba_t fore;
  } pixel_t;

  typedef struct packed {
    logic [7:0] back_index;
    logic [7:0] fore_index;
  } index_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pixel_t      drive_pixel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  back_index;
  logic [7:0]  fore_index;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_to_256_colour_index_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .back_red   (drive_pixel.back.red),
    .back_green (drive_pixel.back.green),
    .back_blue  (drive_pixel.back.blue),
    .back_alpha (drive_pixel.back.alpha),
    .fore_red   (drive_pixel.fore.red),
    .fore_green (drive_pixel.fore.green),
    .fore_blue  (drive_pixel.fore.blue),
    .fore_alpha (drive_pixel.fore.alpha),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .back_index (back_index),
    .fore_index (fore_index),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_t      pixel_queue[$];
  index_pair_t expected_indices[$];
  index_pair_t due;
  logic [7:0]  window_setting = GRAY_WINDOW_RESET;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  logic        offering = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          send_idle_max = 0;
  int          recv_idle_max = 0;
  int          receiver_hold = 0;
  int          failures = 0;
  int          accepted_pixels = 0;
  int          settings_used = 1;
  int          cube_count = 0;
  int          gray_count = 0;

  // palette index of one colour under the current gray window
  function automatic logic [7:0] palette_index(input rgba_t c, input logic [7:0] window);
    int pr, pg, pb, luma, lo, hi;
    pr = int'(c.red) * int'(c.alpha) / 255;
    pg = int'(c.green) * int'(c.alpha) / 255;
    pb = int'(c.blue) * int'(c.alpha) / 255;
    luma = (pr + pg + pb) / 3;
    lo = luma - int'(window);
    hi = luma + int'(window);
    if (pr < lo || pr > hi || pg < lo || pg > hi || pb < lo || pb > hi)
      return 8'(CUBE_START + 36 * (pr * 6 / 256) + 6 * (pg * 6 / 256) + pb * 6 / 256);
    return 8'(GRAY_START + luma * 24 / 256);
  endfunction

  // idle cycles before the next transaction, zero about half the time and always zero when max_gap is 0
  function automatic int draw_gap(input int max_gap);
    if (max_gap == 0 || $urandom_range(0, 1) == 0)
      return 0;
    return $urandom_range(1, max_gap);
  endfunction

  // channel byte near a base level, clamped to a byte
  function automatic logic [7:0] near_byte(input int base, input int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // byte at or next to an end of its range
  function automatic logic [7:0] edge_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hfe;
      default: return 8'hff;
    endcase
  endfunction

  // random colour, biased toward grays, opaque and transparent alpha, and range ends
  function automatic rgba_t random_colour();
    rgba_t c;
    int base, spread;
    base = $urandom_range(0, 255);
    spread = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 40);
    case ($urandom_range(0, 9))
      4, 5, 6: begin
        c.red = near_byte(base, spread);
        c.green = near_byte(base, spread);
        c.blue = near_byte(base, spread);
        c.alpha = ($urandom_range(0, 3) != 0) ? 8'hff : 8'($urandom);
      end
      7: begin
        c = $urandom;
        c.alpha = $urandom_range(0, 1) ? 8'h00 : 8'hff;
      end
      8: c = {edge_byte(), edge_byte(), edge_byte(), edge_byte()};
      default: c = $urandom;
    endcase
    return c;
  endfunction

  // apb write: setup then access cycle
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == GRAY_WINDOW_ADDR) begin
      window_setting = data[7:0];
      settings_used++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // apb read of the gray window, compared with the mirrored setting
  task automatic check_window_readback();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= GRAY_WINDOW_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'd0, window_setting}) begin
      $error("gray_window: expected %0d, got %0d", window_setting, prdata);
      failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every pixel is sent and every result is back, then let the pipe settle
  task automatic wait_until_drained();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || in_valid || expected_indices.size() != 0);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
  endtask

  // one setting of the gray window with random pixels
  task automatic run_phase(input logic [31:0] window_word, input int count, input int send_max,
                           input int recv_max, input int hold);
    write_register(GRAY_WINDOW_ADDR, window_word);
    check_window_readback();
    send_idle_max = send_max;
    recv_idle_max = recv_max;
    receiver_hold = hold;
    repeat (count) pixel_queue.push_back({random_colour(), random_colour()});
    wait_until_drained();
  endtask

  // input driver: next pending pixel after the drawn gap, held while stalled
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        in_fire = 1'b0;
        offering = 1'b0;
        send_gap = draw_gap(send_idle_max);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pixel_queue.size() != 0) begin
          drive_pixel <= pixel_queue.pop_front();
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // output stall: long hold when asked, else a drawn stall after each result
  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) begin
        out_fire = 1'b0;
        recv_gap = draw_gap(recv_idle_max);
      end
      if (receiver_hold > 0) begin
        receiver_hold--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      due.back_index = palette_index(drive_pixel.back, window_setting);
      due.fore_index = palette_index(drive_pixel.fore, window_setting);
      expected_indices.push_back(due);
      if (due.back_index >= GRAY_START) gray_count++; else cube_count++;
      if (due.fore_index >= GRAY_START) gray_count++; else cube_count++;
      accepted_pixels++;
      in_fire = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      out_fire = 1'b1;
      if (expected_indices.size() == 0) begin
        $error("result with no pending pixel: back_index %0d, fore_index %0d",
               back_index, fore_index);
        failures++;
      end else begin
        due = expected_indices.pop_front();
        if (back_index !== due.back_index) begin
          $error("back_index: expected %0d, got %0d", due.back_index, back_index);
          failures++;
        end
        if (fore_index !== due.fore_index) begin
          $error("fore_index: expected %0d, got %0d", due.fore_index, fore_index);
          failures++;
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_window_readback();

    // directed pixels under the reset window
    send_idle_max = MAX_IDLE;
    recv_idle_max = MAX_IDLE;
    pixel_queue.push_back({32'h0000_0000, 32'hffff_ffff});
    pixel_queue.push_back({32'hffff_ff00, 32'h0000_00ff});
    pixel_queue.push_back({32'hff00_00ff, 32'h00ff_00ff});
    pixel_queue.push_back({32'h0000_ffff, 32'hff00_ffff});
    // window edge above and below the luminance
    pixel_queue.push_back({8'd133, 8'd100, 8'd100, 8'hff, 8'd134, 8'd100, 8'd100, 8'hff});
    pixel_queue.push_back({8'd66, 8'd100, 8'd100, 8'hff, 8'd65, 8'd100, 8'd100, 8'hff});
    pixel_queue.push_back({8'd100, 8'd133, 8'd100, 8'hff, 8'd100, 8'd100, 8'd65, 8'hff});
    // partial alpha
    pixel_queue.push_back({8'd200, 8'd50, 8'd10, 8'd128, 8'd255, 8'd255, 8'd255, 8'd1});
    pixel_queue.push_back({8'd1, 8'd1, 8'd1, 8'hff, 8'd255, 8'd0, 8'd255, 8'd254});
    pixel_queue.push_back({8'd128, 8'd128, 8'd128, 8'hff, 8'd255, 8'd255, 8'd255, 8'd128});
    // cube cell boundaries and near-gray
    pixel_queue.push_back({8'd42, 8'd43, 8'd85, 8'hff, 8'd213, 8'd214, 8'd170, 8'hff});
    pixel_queue.push_back({8'd254, 8'd254, 8'd255, 8'hff, 8'd10, 8'd11, 8'd12, 8'hff});
    pixel_queue.push_back({8'd255, 8'd255, 8'd0, 8'hff, 8'd0, 8'd255, 8'd255, 8'hff});
    wait_until_drained();

    // random pixels over several window settings and idling mixes
    repeat (200) pixel_queue.push_back({random_colour(), random_colour()});
    wait_until_drained();
    run_phase(32'd0, 250, 0, 0, 0);
    run_phase(32'd255, 200, MAX_IDLE, 3, 0);
    run_phase(32'd1, 200, 0, 5, 300);
    write_register(UNMAPPED_ADDR, 32'h0000_00ff);
    check_window_readback();
    run_phase(32'd254, 150, 5, 5, 0);
    repeat (3)
      run_phase({24'($urandom), 8'($urandom)}, 150, MAX_IDLE, MAX_IDLE, 0);
    run_phase(32'd128, 150, 3, 0, 0);

    if (expected_indices.size() != 0) begin
      $error("%0d expected results never arrived", expected_indices.size());
      failures++;
    end
    $display("covered %0d pixels over %0d gray window settings", accepted_pixels, settings_used);
    $display("predicted %0d cube and %0d gray colours", cube_count, gray_count);
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
